// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sorted table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/stig_pkg.sv =====
// Package: sizes, codes and controller/datapath types of the sorted table.
package stig_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_INSERT,
        ST_REMOVE,
        ST_GET,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_start;
        logic ins_step;
        logic rem_step;
        logic get_cap;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              bad_idx;
        logic              ins_done;
        logic              rem_none;
        logic              rem_end;
    } t_dp_status;

endpackage

// ===== hdl/stig_if.sv =====
// Request and response channel interfaces of the sorted table.
interface stig_req_if;
    import stig_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [FUNC_W-1:0]            func;
    logic signed [VALUE_BITS-1:0] value;
    logic [INDEX_W-1:0]           index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface stig_rsp_if;
    import stig_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [STATUS_W-1:0]          status;
    logic [COUNT_W-1:0]           entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

// ===== hdl/stig_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hdl/stig_datapath.sv =====
// Datapath: count, request registers, entry RAM access and result registers.
module stig_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stig_pkg::t_dp_cmd                      i_cmd,
    output stig_pkg::t_dp_status                   o_stat,
    input  logic [stig_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [stig_pkg::VALUE_BITS-1:0] i_value,
    input  logic [stig_pkg::INDEX_W-1:0]           i_index,
    output logic signed [stig_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [stig_pkg::STATUS_W-1:0]          o_status,
    output logic [stig_pkg::COUNT_W-1:0]           o_entry_count
);
    `include "assert_macros.svh"
    import stig_pkg::*;

    localparam int CMP_W = CNT_BITS + INDEX_W;

    logic [CNT_BITS-1:0]          r_count;
    logic [CNT_BITS-1:0]          n_count;
    logic [FUNC_W-1:0]            r_func;
    logic signed [VALUE_BITS-1:0] r_value;
    logic signed [VALUE_BITS-1:0] r_get;
    logic                         r_bad;
    logic [CNT_BITS-1:0]          r_ptr;
    logic [CNT_BITS-1:0]          n_ptr;

    logic signed [VALUE_BITS-1:0] r_out_value;
    logic [STATUS_W-1:0]          r_out_status;
    logic [COUNT_W-1:0]           r_out_count;
    logic signed [VALUE_BITS-1:0] n_out_value;
    logic [STATUS_W-1:0]          n_out_status;

    logic [CMP_W-1:0]             idx_ext;
    logic [CMP_W-1:0]             cnt_ext;
    logic [CNT_BITS+COUNT_W-1:0]  cnt_out_ext;
    logic [CNT_BITS:0]            ptr_ext;
    logic [CNT_BITS:0]            count_ext;
    logic                         full;
    logic                         ins_stop;

    logic                         wr_en;
    logic [VALUE_BITS-1:0]        wr_data;
    logic [CNT_BITS-1:0]          rd_ptr;
    logic [VALUE_BITS-1:0]        rd_data;

    stig_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_ptr[IDX_BITS-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_ptr[IDX_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    assign idx_ext   = {{CNT_BITS{1'b0}}, i_index};
    assign cnt_ext   = {{INDEX_W{1'b0}}, r_count};
    assign ptr_ext   = {1'b0, r_ptr};
    assign count_ext = {1'b0, r_count};
    assign full      = (r_count >= CNT_BITS'(CAPACITY));
    assign ins_stop  = ($signed(rd_data) < r_value);

    always_comb begin
        o_stat.func     = r_func;
        o_stat.full     = full;
        o_stat.bad_idx  = r_bad;
        o_stat.ins_done = (r_ptr == '0) || ins_stop;
        o_stat.rem_none = (ptr_ext + (CNT_BITS+1)'(1)) >= count_ext;
        o_stat.rem_end  = (ptr_ext + (CNT_BITS+1)'(2)) >= count_ext;
    end

    // Insert walks down from the top, remove walks up from the rank; the
    // read for the next step is issued while this step writes.
    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_data;
        rd_ptr  = r_ptr;
        n_ptr   = r_ptr;
        if (i_cmd.load) begin
            n_ptr = (i_func == FUNC_INSERT) ? r_count : idx_ext[CNT_BITS-1:0];
        end
        if (i_cmd.rd_start) begin
            case (r_func)
                FUNC_INSERT: rd_ptr = r_ptr - CNT_BITS'(1);
                FUNC_REMOVE: rd_ptr = r_ptr + CNT_BITS'(1);
                default:     rd_ptr = r_ptr;
            endcase
        end
        if (i_cmd.ins_step) begin
            wr_en = 1'b1;
            if (o_stat.ins_done) begin
                wr_data = r_value;
            end else begin
                n_ptr  = r_ptr - CNT_BITS'(1);
                rd_ptr = r_ptr - CNT_BITS'(2);
            end
        end
        if (i_cmd.rem_step) begin
            wr_en  = 1'b1;
            n_ptr  = r_ptr + CNT_BITS'(1);
            rd_ptr = r_ptr + CNT_BITS'(2);
        end
    end

    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = STATUS_OK;
        case (r_func)
            FUNC_INSERT: begin
                if (full) begin
                    n_out_status = STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            FUNC_GET: begin
                if (r_bad) begin
                    n_out_status = STATUS_BAD_INDEX;
                end else begin
                    n_out_value = r_get;
                end
            end
            FUNC_REMOVE: begin
                if (r_bad) begin
                    n_out_status = STATUS_BAD_INDEX;
                end else begin
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign cnt_out_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_bad   <= (idx_ext >= cnt_ext);
        end
        if (i_cmd.get_cap) begin
            r_get <= $signed(rd_data);
        end
        if (i_cmd.finish) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_count  <= cnt_out_ext[COUNT_W-1:0];
        end
    end

    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    `ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(CAPACITY), "count above capacity")
    `ASSERT_RST(a_insert_grows, i_clk, i_rst_n, (i_cmd.finish && r_func == FUNC_INSERT && !full) |=> (r_count == $past(r_count) + CNT_BITS'(1)), "insert did not grow count")
endmodule

// ===== hdl/stig_ctrl.sv =====
// Controller: request sequencing state machine and response valid.
module stig_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  stig_pkg::t_dp_status i_stat,
    output stig_pkg::t_dp_cmd    o_cmd
);
    `include "assert_macros.svh"
    import stig_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.full) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = ST_INSERT;
                        end
                    end
                    FUNC_GET: begin
                        if (i_stat.bad_idx) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = ST_GET;
                        end
                    end
                    FUNC_REMOVE: begin
                        // removing the last entry needs no shifting
                        if (i_stat.bad_idx || i_stat.rem_none) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = ST_REMOVE;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_INSERT: begin
                o_cmd.ins_step = 1'b1;
                if (i_stat.ins_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_REMOVE: begin
                o_cmd.rem_step = 1'b1;
                if (i_stat.rem_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_GET: begin
                o_cmd.get_cap = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "second beat taken while busy")
    `ASSERT_RST(a_finish_result, i_clk, i_rst_n, o_cmd.finish |=> r_out_valid, "finished request left no result")
endmodule

// ===== hdl/sorted_table_insert_get_remove.sv =====
// Insert: START, then INSERT shifts one entry per step, then FINISH loads the result.
// Remove shifts entries above the rank; flagged or unused-code requests skip to FINISH.
// One request at a time: the next beat is taken the cycle after the result is loaded.
// The entry RAM's single read and write port sets one shift per cycle.
// A finished result sits in an output register; a stalled output holds the next request.
// Synchronous active-low reset empties the table; entry RAM contents are not cleared.
module sorted_table_insert_get_remove (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stig_req_if.sink        i_req,
    stig_rsp_if.source      o_rsp
);
    import stig_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status stat;

    stig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    stig_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_req.func),
        .i_value       (i_req.value),
        .i_index       (i_req.index),
        .o_read_value  (o_rsp.read_value),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );
endmodule
